[rtl/abrf_pkg.sv]
// ----------------------------------------------------------------------------
// abrf_pkg
// Shared types and constants for the audio block ring FIFO.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package abrf_pkg;

   localparam int FRAMES_W = 7;

   localparam logic [1:0] CHANNEL_COUNT_RESET = 2'd1;
   localparam logic       ACCEPT_RESET        = 1'b0;
   localparam logic [4:0] SLOT_LIMIT_RESET    = 5'd16;
   localparam logic [6:0] MAX_FRAMES_RESET    = 7'd64;
   localparam logic [1:0] CHANNEL_COUNT_STEREO = 2'd2;

   typedef enum logic [1:0] {
      REG_CHANNEL_COUNT = 2'd0,
      REG_ACCEPT_ENABLE = 2'd1,
      REG_SLOT_LIMIT    = 2'd2,
      REG_MAX_FRAMES    = 2'd3
   } reg_index_type;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_READ  = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_OVERSIZE  = 3'd1,
      STATUS_NOT_ACCEPT = 3'd2,
      STATUS_FULL      = 3'd3,
      STATUS_EMPTY     = 3'd4,
      STATUS_CAPACITY  = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_COUNT,
      S_DATA
   } state_type;

   typedef struct packed {
      logic [1:0] channel_count;
      logic       accept_enable;
      logic [4:0] slot_limit;
      logic [6:0] max_frames;
   } cfg_type;

   typedef struct packed {
      logic write_beat;
      logic load_empty;
      logic count_read;
      logic load_cap_fail;
      logic first_read;
      logic load_frame;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic occ_zero;
      logic cap_ok;
      logic frame_last;
   } stat_type;

endpackage

[rtl/abrf_ram.sv]
// ----------------------------------------------------------------------------
// abrf_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// Read data holds while rd_en is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module abrf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/abrf_csr.sv]
// ----------------------------------------------------------------------------
// abrf_csr
// Configuration registers behind the APB-style port. A slot_limit write
// also pulses ring_clear to empty the ring.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module abrf_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [3:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output abrf_pkg::cfg_type    cfg,
   output logic                 ring_clear
);

   abrf_pkg::cfg_type       cfg_ff;
   abrf_pkg::cfg_type       cfg_in;
   abrf_pkg::reg_index_type idx;
   logic                    wr;

   assign idx = abrf_pkg::reg_index_type'(paddr[3:2]);
   assign wr  = psel & penable & pwrite;

   always_comb begin
      cfg_in     = cfg_ff;
      ring_clear = 1'b0;
      if (wr) begin
         unique case (idx)
            abrf_pkg::REG_CHANNEL_COUNT: cfg_in.channel_count = pwdata[1:0];
            abrf_pkg::REG_ACCEPT_ENABLE: cfg_in.accept_enable = pwdata[0];
            abrf_pkg::REG_SLOT_LIMIT: begin
               cfg_in.slot_limit = pwdata[4:0];
               ring_clear        = 1'b1;
            end
            abrf_pkg::REG_MAX_FRAMES:    cfg_in.max_frames = pwdata[6:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.channel_count <= abrf_pkg::CHANNEL_COUNT_RESET;
         cfg_ff.accept_enable <= abrf_pkg::ACCEPT_RESET;
         cfg_ff.slot_limit    <= abrf_pkg::SLOT_LIMIT_RESET;
         cfg_ff.max_frames    <= abrf_pkg::MAX_FRAMES_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (idx)
         abrf_pkg::REG_CHANNEL_COUNT: prdata = {30'd0, cfg_ff.channel_count};
         abrf_pkg::REG_ACCEPT_ENABLE: prdata = {31'd0, cfg_ff.accept_enable};
         abrf_pkg::REG_SLOT_LIMIT:    prdata = {27'd0, cfg_ff.slot_limit};
         abrf_pkg::REG_MAX_FRAMES:    prdata = {25'd0, cfg_ff.max_frames};
      endcase
   end

   assign cfg = cfg_ff;

endmodule

[rtl/abrf_datapath.sv]
// ----------------------------------------------------------------------------
// abrf_datapath
// Ring pointers, open-block tracking, drop counter, sample and count RAMs
// and the result register. Acts on commands from abrf_ctrl.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module abrf_datapath #(
   parameter int SLOTS       = 16,
   parameter int MAX_FRAMES  = 64,
   parameter int SAMPLE_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  abrf_pkg::cfg_type      cfg,
   input  logic                   ring_clear,
   input  abrf_pkg::cmd_type      cmd,
   output abrf_pkg::stat_type     stat,
   input  logic [31:0]            sample_zero,
   input  logic [31:0]            sample_one,
   input  logic                   last_frame,
   input  logic [6:0]             read_room,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output abrf_pkg::status_type   rsp_status,
   output logic [31:0]            rsp_out_zero,
   output logic [31:0]            rsp_out_one,
   output logic [6:0]             rsp_block_frames,
   output logic                   rsp_last,
   output logic [31:0]            rsp_dropped_count
);

   localparam int SW    = $clog2(SLOTS);
   localparam int FB    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int AW    = SW + FB;
   localparam int DEPTH = SLOTS << FB;
   localparam int OW    = $clog2(SLOTS + 1);
   localparam int CW    = (OW > 5) ? OW : 5;

   // control state
   logic [SW-1:0] head_ff, head_in;
   logic [SW-1:0] tail_ff, tail_in;
   logic [OW-1:0] occ_ff, occ_in;
   logic [6:0]    fill_ff, fill_in;
   logic          open_ff, open_in;
   logic          noacc_ff, noacc_in;
   logic          full_ff, full_in;
   logic [31:0]   drop_ff, drop_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // payload
   logic [6:0]    cap_ff, blk_frames_ff;
   logic [FB-1:0] rd_frame_ff;
   abrf_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [31:0]   rsp_zero_ff, rsp_zero_in;
   logic [31:0]   rsp_one_ff, rsp_one_in;
   logic [6:0]    rsp_frames_ff, rsp_frames_in;
   logic          rsp_last_ff, rsp_last_in;
   logic [31:0]   rsp_drop_ff, rsp_drop_in;

   // derived
   logic [CW-1:0] lim_ext;
   logic [OW-1:0] eff_slots;
   logic [6:0]    eff_max;
   logic [OW-1:0] tail_inc, head_inc;
   logic [SW-1:0] tail_adv, head_adv;
   logic          stereo;
   logic          first, noacc_now, full_now, store;
   logic [6:0]    fill_cur, fill_next;
   logic [31:0]   drop_sat;
   logic          out_free, frame_last;

   // RAM ports
   logic                   data_rd_en;
   logic [AW-1:0]          data_wr_addr, data_rd_addr;
   logic [SAMPLE_BITS-1:0] wr_zero, wr_one, rd_zero, rd_one;
   logic                   cnt_wr_en;
   logic [6:0]             cnt_rd;

   assign stereo  = (cfg.channel_count == abrf_pkg::CHANNEL_COUNT_STEREO);
   assign lim_ext = CW'(cfg.slot_limit);

   always_comb begin
      if (cfg.slot_limit < 5'd2) begin
         eff_slots = OW'(2);
      end else if (lim_ext > CW'(SLOTS)) begin
         eff_slots = OW'(SLOTS);
      end else begin
         eff_slots = lim_ext[OW-1:0];
      end
      if (cfg.max_frames == 7'd0) begin
         eff_max = 7'd1;
      end else if (cfg.max_frames > 7'(MAX_FRAMES)) begin
         eff_max = 7'(MAX_FRAMES);
      end else begin
         eff_max = cfg.max_frames;
      end
   end

   assign tail_inc = OW'(tail_ff) + OW'(1);
   assign head_inc = OW'(head_ff) + OW'(1);
   assign tail_adv = (tail_inc >= eff_slots) ? '0 : tail_inc[SW-1:0];
   assign head_adv = (head_inc >= eff_slots) ? '0 : head_inc[SW-1:0];

   assign first     = !open_ff;
   assign noacc_now = first ? !cfg.accept_enable : noacc_ff;
   assign full_now  = first ? (occ_ff >= eff_slots) : full_ff;
   assign fill_cur  = first ? 7'd0 : fill_ff;
   assign fill_next = (fill_cur == 7'd127) ? fill_cur : fill_cur + 7'd1;
   assign store     = cmd.write_beat && !noacc_now && !full_now &&
                      (fill_cur < 7'(MAX_FRAMES));
   assign drop_sat  = (drop_ff == 32'hFFFF_FFFF) ? drop_ff : drop_ff + 32'd1;

   assign wr_zero      = sample_zero[SAMPLE_BITS-1:0];
   assign wr_one       = stereo ? sample_one[SAMPLE_BITS-1:0] : '0;
   assign data_wr_addr = {tail_ff, fill_cur[FB-1:0]};

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign frame_last = (7'(rd_frame_ff) + 7'd1 == blk_frames_ff);

   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      occ_in        = occ_ff;
      fill_in       = fill_ff;
      open_in       = open_ff;
      noacc_in      = noacc_ff;
      full_in       = full_ff;
      drop_in       = drop_ff;
      cnt_wr_en     = 1'b0;
      data_rd_en    = 1'b0;
      data_rd_addr  = {head_ff, FB'(0)};
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_zero_in   = rsp_zero_ff;
      rsp_one_in    = rsp_one_ff;
      rsp_frames_in = rsp_frames_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_drop_in   = rsp_drop_ff;

      if (cmd.write_beat) begin
         if (!last_frame) begin
            fill_in  = fill_next;
            open_in  = 1'b1;
            noacc_in = noacc_now;
            full_in  = full_now;
         end else begin
            fill_in  = 7'd0;
            open_in  = 1'b0;
            noacc_in = 1'b0;
            full_in  = 1'b0;
            if (fill_next > eff_max) begin
               rsp_status_in = abrf_pkg::STATUS_OVERSIZE;
               drop_in       = drop_sat;
            end else if (noacc_now) begin
               rsp_status_in = abrf_pkg::STATUS_NOT_ACCEPT;
            end else if (full_now) begin
               rsp_status_in = abrf_pkg::STATUS_FULL;
               drop_in       = drop_sat;
            end else begin
               rsp_status_in = abrf_pkg::STATUS_OK;
               cnt_wr_en     = 1'b1;
               tail_in       = tail_adv;
               occ_in        = occ_ff + OW'(1);
            end
            rsp_valid_in  = 1'b1;
            rsp_zero_in   = 32'd0;
            rsp_one_in    = 32'd0;
            rsp_frames_in = fill_next;
            rsp_last_in   = 1'b1;
            rsp_drop_in   = drop_in;
         end
      end

      if (cmd.load_empty || cmd.load_cap_fail) begin
         rsp_valid_in  = 1'b1;
         if (cmd.load_empty) begin
            rsp_status_in = abrf_pkg::STATUS_EMPTY;
            rsp_frames_in = 7'd0;
         end else begin
            rsp_status_in = abrf_pkg::STATUS_CAPACITY;
            rsp_frames_in = cnt_rd;
         end
         rsp_zero_in   = 32'd0;
         rsp_one_in    = 32'd0;
         rsp_last_in   = 1'b1;
         rsp_drop_in   = drop_ff;
      end

      if (cmd.first_read) begin
         data_rd_en = 1'b1;
      end

      if (cmd.load_frame) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = abrf_pkg::STATUS_OK;
         rsp_zero_in   = 32'(rd_zero);
         rsp_one_in    = stereo ? 32'(rd_one) : 32'd0;
         rsp_frames_in = blk_frames_ff;
         rsp_last_in   = frame_last;
         rsp_drop_in   = drop_ff;
         if (frame_last) begin
            head_in = head_adv;
            occ_in  = occ_ff - OW'(1);
         end else begin
            data_rd_en   = 1'b1;
            data_rd_addr = {head_ff, rd_frame_ff + FB'(1)};
         end
      end

      if (ring_clear) begin
         head_in = '0;
         tail_in = '0;
         occ_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         fill_ff      <= '0;
         open_ff      <= 1'b0;
         noacc_ff     <= 1'b0;
         full_ff      <= 1'b0;
         drop_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         fill_ff      <= fill_in;
         open_ff      <= open_in;
         noacc_ff     <= noacc_in;
         full_ff      <= full_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_zero_ff   <= rsp_zero_in;
      rsp_one_ff    <= rsp_one_in;
      rsp_frames_ff <= rsp_frames_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_drop_ff   <= rsp_drop_in;
      if (cmd.count_read) begin
         cap_ff <= read_room;
      end
      if (cmd.first_read) begin
         blk_frames_ff <= cnt_rd;
         rd_frame_ff   <= '0;
      end else if (cmd.load_frame && !frame_last) begin
         rd_frame_ff <= rd_frame_ff + FB'(1);
      end
   end

   abrf_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (DEPTH)
   ) u_ram_zero (
      .clock   (clock),
      .wr_en   (store),
      .wr_addr (data_wr_addr),
      .wr_data (wr_zero),
      .rd_en   (data_rd_en),
      .rd_addr (data_rd_addr),
      .rd_data (rd_zero)
   );

   abrf_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (DEPTH)
   ) u_ram_one (
      .clock   (clock),
      .wr_en   (store),
      .wr_addr (data_wr_addr),
      .wr_data (wr_one),
      .rd_en   (data_rd_en),
      .rd_addr (data_rd_addr),
      .rd_data (rd_one)
   );

   abrf_ram #(
      .WIDTH (abrf_pkg::FRAMES_W),
      .DEPTH (SLOTS)
   ) u_ram_count (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (tail_ff),
      .wr_data (fill_next),
      .rd_en   (cmd.count_read),
      .rd_addr (head_ff),
      .rd_data (cnt_rd)
   );

   assign stat.out_free   = out_free;
   assign stat.occ_zero   = (occ_ff == '0);
   assign stat.cap_ok     = (cnt_rd != 7'd0) && (cnt_rd <= cap_ff);
   assign stat.frame_last = frame_last;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_out_zero      = rsp_zero_ff;
   assign rsp_out_one       = rsp_one_ff;
   assign rsp_block_frames  = rsp_frames_ff;
   assign rsp_last          = rsp_last_ff;
   assign rsp_dropped_count = rsp_drop_ff;

endmodule

[rtl/abrf_ctrl.sv]
// ----------------------------------------------------------------------------
// abrf_ctrl
// Sequencer: takes request beats, walks a read through count lookup and
// frame streaming, and issues datapath commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module abrf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  abrf_pkg::op_type     req_op,
   output logic                 req_ready,
   input  abrf_pkg::stat_type   stat,
   output abrf_pkg::cmd_type    cmd
);

   abrf_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= abrf_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         abrf_pkg::S_IDLE: begin
            req_ready = stat.out_free;
            if (req_valid && stat.out_free) begin
               if (req_op == abrf_pkg::OP_WRITE) begin
                  cmd.write_beat = 1'b1;
               end else if (stat.occ_zero) begin
                  cmd.load_empty = 1'b1;
               end else begin
                  cmd.count_read = 1'b1;
                  state_in       = abrf_pkg::S_COUNT;
               end
            end
         end
         abrf_pkg::S_COUNT: begin
            if (stat.cap_ok) begin
               cmd.first_read = 1'b1;
               state_in       = abrf_pkg::S_DATA;
            end else if (stat.out_free) begin
               cmd.load_cap_fail = 1'b1;
               state_in          = abrf_pkg::S_IDLE;
            end
         end
         abrf_pkg::S_DATA: begin
            if (stat.out_free) begin
               cmd.load_frame = 1'b1;
               if (stat.frame_last) begin
                  state_in = abrf_pkg::S_IDLE;
               end
            end
         end
         default: begin
            state_in = abrf_pkg::S_IDLE;
         end
      endcase
   end

endmodule

[rtl/audio_block_ring_fifo.sv]
// ----------------------------------------------------------------------------
// audio_block_ring_fifo
// FIFO of audio blocks kept in SLOTS slots of up to MAX_FRAMES mono or
// stereo frames. Write beats (req_tuser = 0) carry one frame each, req_tlast
// on the block's last frame; that last beat returns one status beat and
// middle frames return nothing. A read beat (req_tuser = 1) pops the head
// block as a run of frame beats with rsp_tlast on the last, or returns one
// status beat if the ring is empty or req capacity is too small. A read
// first does the slot frame-count lookup (registered count RAM read), then
// the first sample RAM read, then streams one frame per cycle while the
// result register is free. A status-only read answers from idle when the
// ring is empty, and after the count lookup when the capacity is too small.
// A full result register stalls new requests until rsp_tready.
// Sample and count RAMs need no clearing after reset. Writing slot_limit
// empties the ring.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module audio_block_ring_fifo #(
   parameter int SLOTS       = 16,
   parameter int MAX_FRAMES  = 64,
   parameter int SAMPLE_BITS = 32
) (
   input  logic          clock,
   input  logic          reset,
   // request stream
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [71:0]   req_tdata,  // sample_zero, sample_one, read capacity
   input  logic          req_tuser,  // operation
   input  logic          req_tlast,  // last_frame
   // result stream
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [111:0]  rsp_tdata,  // status, out_zero, out_one, block_frames,
                                     // dropped_count
   output logic          rsp_tlast,  // last_result
   // configuration
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [3:0]    csr_paddr,
   input  logic [31:0]   csr_pwdata,
   output logic [31:0]   csr_prdata,
   output logic          csr_pready
);

   abrf_pkg::cfg_type    cfg;
   abrf_pkg::cmd_type    cmd;
   abrf_pkg::stat_type   stat;
   abrf_pkg::status_type rsp_status;
   logic                 ring_clear;
   logic [31:0]          rsp_out_zero, rsp_out_one, rsp_dropped_count;
   logic [6:0]           rsp_block_frames;

   assign csr_pready = 1'b1;

   abrf_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (csr_psel),
      .penable    (csr_penable),
      .pwrite     (csr_pwrite),
      .paddr      (csr_paddr),
      .pwdata     (csr_pwdata),
      .prdata     (csr_prdata),
      .cfg        (cfg),
      .ring_clear (ring_clear)
   );

   abrf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_op    (abrf_pkg::op_type'(req_tuser)),
      .req_ready (req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   abrf_datapath #(
      .SLOTS       (SLOTS),
      .MAX_FRAMES  (MAX_FRAMES),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .ring_clear        (ring_clear),
      .cmd               (cmd),
      .stat              (stat),
      .sample_zero       (req_tdata[31:0]),
      .sample_one        (req_tdata[63:32]),
      .last_frame        (req_tlast),
      .read_room         (req_tdata[70:64]),
      .rsp_ready         (rsp_tready),
      .rsp_valid         (rsp_tvalid),
      .rsp_status        (rsp_status),
      .rsp_out_zero      (rsp_out_zero),
      .rsp_out_one       (rsp_out_one),
      .rsp_block_frames  (rsp_block_frames),
      .rsp_last          (rsp_tlast),
      .rsp_dropped_count (rsp_dropped_count)
   );

   assign rsp_tdata = {6'd0, rsp_dropped_count, rsp_block_frames, rsp_out_one,
                       rsp_out_zero, rsp_status};

endmodule
